### src/tpwm_pkg.sv
// Shared types and constants for the three-phase PWM dead-time generator.
`timescale 1ns / 1ps

package tpwm_pkg;

  localparam int PERIOD_W  = 16;
  localparam int DUTY_W    = 16;
  localparam int DEAD_W    = 10;
  localparam int MIN_W     = 10;
  localparam int STEP_W    = 3;
  localparam int CFG_IDX_W = 8;
  localparam int CFG_DAT_W = 16;
  // signed width that holds period - on - 2*dead and duty*period/65536 - dead
  localparam int CALC_W    = 18;
  localparam int OUT_PHASES = 3;

  localparam logic [PERIOD_W-1:0] PERIOD_RESET = 16'd1000;
  localparam logic [DEAD_W-1:0]   DEAD_RESET   = 10'd2;
  localparam logic [MIN_W-1:0]    MIN_RESET    = 10'd1;
  localparam logic                WAVE_RESET   = 1'b0;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PERIOD = 8'd0,
    REG_DEAD   = 8'd1,
    REG_MIN    = 8'd2,
    REG_WAVE   = 8'd3
  } cfg_reg_t;

  typedef enum logic {
    WAVE_SAW = 1'b0,
    WAVE_TRI = 1'b1
  } wave_t;

  // sequencer steps
  localparam logic [STEP_W-1:0] STEP_IDLE  = 3'd0;
  localparam logic [STEP_W-1:0] STEP_ONE   = 3'd1;
  localparam logic [STEP_W-1:0] STEP_TWO   = 3'd2;
  localparam logic [STEP_W-1:0] STEP_THREE = 3'd3;
  localparam logic [STEP_W-1:0] STEP_FOUR  = 3'd4;
  localparam logic [STEP_W-1:0] STEP_FIVE  = 3'd5;

  typedef struct packed {
    logic [PERIOD_W-1:0] period_ticks;
    logic [DEAD_W-1:0]   dead_ticks;
    logic [MIN_W-1:0]    min_ticks;
    wave_t               wave_mode;
  } cfg_t;

  typedef struct packed {
    logic              run;
    logic [DUTY_W-1:0] duty_u;
    logic [DUTY_W-1:0] duty_v;
    logic [DUTY_W-1:0] duty_w;
  } in_item_t;

  typedef struct packed {
    logic              gate_u_high;
    logic              gate_u_low;
    logic              gate_v_high;
    logic              gate_v_low;
    logic              gate_w_high;
    logic              gate_w_low;
    logic [STEP_W-1:0] step_u;
    logic [STEP_W-1:0] step_v;
    logic [STEP_W-1:0] step_w;
  } out_item_t;

  typedef struct packed {
    logic              high;
    logic              low;
    logic [STEP_W-1:0] step;
  } phase_out_t;

endpackage

### src/tpwm_if.sv
// Stream and configuration-write interfaces.
`timescale 1ns / 1ps

interface tpwm_stream_if #(
  parameter type payload_t = logic
) ();
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

interface tpwm_cfg_if
  import tpwm_pkg::*;
();
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [CFG_DAT_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

### src/tpwm_cfg_regs.sv
// Configuration register bank: period, dead time, minimum duration, wave mode.
`timescale 1ns / 1ps

module tpwm_cfg_regs
  import tpwm_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  tpwm_cfg_if.sink    cfg_ch,
  output cfg_t        cfg
);

  cfg_t regs;

  assign cfg_ch.ready = 1'b1;
  assign cfg = regs;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs.period_ticks <= PERIOD_RESET;
      regs.dead_ticks   <= DEAD_RESET;
      regs.min_ticks    <= MIN_RESET;
      regs.wave_mode    <= wave_t'(WAVE_RESET);
    end else if (cfg_ch.valid) begin
      unique case (cfg_ch.index)
        REG_PERIOD: regs.period_ticks <= cfg_ch.data[PERIOD_W-1:0];
        REG_DEAD:   regs.dead_ticks   <= cfg_ch.data[DEAD_W-1:0];
        REG_MIN:    regs.min_ticks    <= cfg_ch.data[MIN_W-1:0];
        REG_WAVE:   regs.wave_mode    <= wave_t'(cfg_ch.data[0]);
        default: begin
        end
      endcase
    end
  end

endmodule

### src/tpwm_phase_seq.sv
// One phase leg sequencer: latches on/off times per period and steps through the gate pattern.
`timescale 1ns / 1ps

module tpwm_phase_seq
  import tpwm_pkg::*;
#(
  parameter int TICK_WIDTH = 16
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              en,
  input  logic              run,
  input  logic [DUTY_W-1:0] prod,   // duty * period / 65536, taken at the input stage
  input  cfg_t              cfg,
  output phase_out_t        result
);

  localparam logic [15:0] TickMax16 =
    (TICK_WIDTH >= 16) ? 16'hFFFF : 16'((32'd1 << TICK_WIDTH) - 32'd1);

  logic [STEP_W-1:0]     step;
  logic [TICK_WIDTH-1:0] ticks_left;
  logic [TICK_WIDTH-1:0] on_time;
  logic [TICK_WIDTH-1:0] off_time;

  logic [STEP_W-1:0]     step_next;
  logic [TICK_WIDTH-1:0] ticks_left_next;
  logic [TICK_WIDTH-1:0] on_time_next;
  logic [TICK_WIDTH-1:0] off_time_next;

  logic [STEP_W-1:0]     last_step;
  logic [STEP_W-1:0]     n1;
  logic [STEP_W-1:0]     n2;
  logic                  skip;
  logic [MIN_W-1:0]      lo_lim;
  logic [15:0]           dead16;
  logic [TICK_WIDTH-1:0] dead_len;
  logic signed [CALC_W-1:0] on_raw;
  logic signed [CALC_W-1:0] off_raw;
  logic signed [CALC_W-1:0] off_half;
  logic [15:0]           on_c;
  logic [15:0]           off_c;
  logic [TICK_WIDTH-1:0] on_new;
  logic [TICK_WIDTH-1:0] off_new;
  logic [TICK_WIDTH-1:0] len;
  logic                  do_adv;

  function automatic logic [STEP_W-1:0] inc_step(logic [STEP_W-1:0] s,
                                                 logic [STEP_W-1:0] last);
    return (s == STEP_IDLE || s >= last) ? STEP_ONE : s + 3'd1;
  endfunction

  function automatic logic [15:0] clamp16(logic signed [CALC_W-1:0] t,
                                          logic [MIN_W-1:0] lo);
    logic [15:0] v;
    if (t < $signed({8'b0, lo})) v = {6'b0, lo};
    else                         v = t[15:0];
    if (v > TickMax16) v = TickMax16;
    return v;
  endfunction

  always_comb begin
    last_step = (cfg.wave_mode == WAVE_TRI) ? STEP_FIVE : STEP_FOUR;
    lo_lim    = (cfg.min_ticks == '0) ? 10'd1 : cfg.min_ticks;
    dead16    = {6'b0, cfg.dead_ticks};
    dead_len  = TICK_WIDTH'((dead16 > TickMax16) ? TickMax16 : dead16);

    // a zero dead step is skipped; its neighbours never last zero
    n1   = inc_step(step, last_step);
    skip = (n1 == STEP_TWO || n1 == STEP_FOUR) && (cfg.dead_ticks == '0);
    n2   = skip ? inc_step(n1, last_step) : n1;

    on_raw   = $signed({2'b0, prod}) - $signed({8'b0, cfg.dead_ticks});
    on_c     = clamp16(on_raw, lo_lim);
    off_raw  = $signed({2'b0, cfg.period_ticks}) - $signed({2'b0, on_c})
             - $signed({7'b0, cfg.dead_ticks, 1'b0});
    off_half = (cfg.wave_mode == WAVE_TRI && off_raw > 0) ? (off_raw >>> 1) : off_raw;
    off_c    = clamp16(off_half, lo_lim);

    on_new  = (n2 == STEP_ONE) ? TICK_WIDTH'(on_c) : on_time;
    off_new = (n2 == STEP_ONE) ? TICK_WIDTH'(off_c) : off_time;

    if (cfg.wave_mode == WAVE_SAW) begin
      if (n2 == STEP_ONE)        len = on_new;
      else if (n2 == STEP_THREE) len = off_new;
      else                       len = dead_len;
    end else begin
      if (n2 == STEP_ONE || n2 == STEP_FIVE) len = off_new;
      else if (n2 == STEP_THREE)             len = on_new;
      else                                   len = dead_len;
    end

    do_adv          = (step == STEP_IDLE) || (ticks_left == '0);
    step_next       = step;
    ticks_left_next = ticks_left;
    on_time_next    = on_time;
    off_time_next   = off_time;
    if (!run) begin
      step_next       = STEP_IDLE;
      ticks_left_next = '0;
    end else if (do_adv) begin
      step_next       = n2;
      ticks_left_next = (len == '0) ? '0 : len - 1'b1;
      on_time_next    = on_new;
      off_time_next   = off_new;
    end else begin
      ticks_left_next = ticks_left - 1'b1;
    end

    result.step = step_next;
    result.high = 1'b0;
    result.low  = 1'b0;
    if (cfg.wave_mode == WAVE_SAW) begin
      result.high = (step_next == STEP_ONE);
      result.low  = (step_next == STEP_THREE);
    end else begin
      result.high = (step_next == STEP_THREE);
      result.low  = (step_next == STEP_ONE) || (step_next == STEP_FIVE);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step       <= STEP_IDLE;
      ticks_left <= '0;
      on_time    <= '0;
      off_time   <= '0;
    end else if (en) begin
      step       <= step_next;
      ticks_left <= ticks_left_next;
      on_time    <= on_time_next;
      off_time   <= off_time_next;
    end
  end

endmodule

### src/three_phase_pwm_dead_time_top.sv
// Three-phase complementary PWM with dead time: top level.
// A result passes from the input stage register to the output register.
// Throughput: one tick per cycle unless the output stalls; the input stage takes
// the duty products, one multiplier per phase, and the phase sequencers update as
// the item moves on. The input stage accepts a tick while a finished result waits.
// Reset (synchronous, rst high) empties both stages, restores register defaults
// and returns every sequencer to idle.
`timescale 1ns / 1ps

module three_phase_pwm_dead_time_top
  import tpwm_pkg::*;
#(
  parameter int PHASE_COUNT = 3,
  parameter int TICK_WIDTH  = 16
) (
  input logic           clk,
  input logic           rst,
  tpwm_cfg_if.sink      cfg_ch,
  tpwm_stream_if.sink   in_ch,
  tpwm_stream_if.source out_ch
);

  cfg_t cfg;

  logic              s1_valid;
  logic              s1_run;
  logic [DUTY_W-1:0] s1_prod [PHASE_COUNT];
  logic              out_valid;
  out_item_t         out_payload;
  out_item_t         out_payload_next;

  logic              adv;
  logic              in_fire;
  in_item_t          in_item;
  logic [DUTY_W-1:0] duty_in [OUT_PHASES];
  phase_out_t        ph_res [PHASE_COUNT];
  phase_out_t        ph_shown [OUT_PHASES];

  tpwm_cfg_regs u_cfg (
    .clk    (clk),
    .rst    (rst),
    .cfg_ch (cfg_ch),
    .cfg    (cfg)
  );

  assign in_item    = in_ch.payload;
  assign duty_in[0] = in_item.duty_u;
  assign duty_in[1] = in_item.duty_v;
  assign duty_in[2] = in_item.duty_w;

  assign adv         = s1_valid && (!out_valid || out_ch.ready);
  assign in_ch.ready = !s1_valid || !out_valid || out_ch.ready;
  assign in_fire     = in_ch.valid && in_ch.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (in_fire)  s1_valid <= 1'b1;
      else if (adv) s1_valid <= 1'b0;
      if (adv)               out_valid <= 1'b1;
      else if (out_ch.ready) out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) s1_run <= in_item.run;
  end

  for (genvar p = 0; p < PHASE_COUNT; p++) begin : g_phase
    logic [2*DUTY_W-1:0] product;
    if (p < OUT_PHASES) begin : g_duty
      assign product = {16'b0, duty_in[p]} * {16'b0, cfg.period_ticks};
    end else begin : g_zero
      assign product = '0;
    end

    always_ff @(posedge clk) begin
      if (in_fire) s1_prod[p] <= product[2*DUTY_W-1:DUTY_W];
    end

    tpwm_phase_seq #(
      .TICK_WIDTH (TICK_WIDTH)
    ) u_seq (
      .clk    (clk),
      .rst    (rst),
      .en     (adv),
      .run    (s1_run),
      .prod   (s1_prod[p]),
      .cfg    (cfg),
      .result (ph_res[p])
    );
  end

  for (genvar q = 0; q < OUT_PHASES; q++) begin : g_show
    if (q < PHASE_COUNT) begin : g_live
      assign ph_shown[q] = ph_res[q];
    end else begin : g_absent
      assign ph_shown[q] = '0;
    end
  end

  always_comb begin
    out_payload_next.gate_u_high = ph_shown[0].high;
    out_payload_next.gate_u_low  = ph_shown[0].low;
    out_payload_next.gate_v_high = ph_shown[1].high;
    out_payload_next.gate_v_low  = ph_shown[1].low;
    out_payload_next.gate_w_high = ph_shown[2].high;
    out_payload_next.gate_w_low  = ph_shown[2].low;
    out_payload_next.step_u      = ph_shown[0].step;
    out_payload_next.step_v      = ph_shown[1].step;
    out_payload_next.step_w      = ph_shown[2].step;
  end

  always_ff @(posedge clk) begin
    if (adv) out_payload <= out_payload_next;
  end

  assign out_ch.valid   = out_valid;
  assign out_ch.payload = out_payload;

endmodule

### src/tpwm_checker.sv
// Port-level checks for the PWM generator, bound to the top level.
`timescale 1ns / 1ps

module tpwm_checker
  import tpwm_pkg::*;
(
  input logic      clk,
  input logic      rst,
  input logic      out_valid,
  input logic      out_ready,
  input out_item_t out_payload
);

  // no shoot-through on any leg
  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(out_payload.gate_u_high && out_payload.gate_u_low)
               && !(out_payload.gate_v_high && out_payload.gate_v_low)
               && !(out_payload.gate_w_high && out_payload.gate_w_low))
    else $error("both gates of a leg on");

  a_idle_off: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_payload.step_u == STEP_IDLE
      |-> !out_payload.gate_u_high && !out_payload.gate_u_low)
    else $error("idle U phase drives a gate");

  a_high_step: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_payload.gate_v_high
      |-> (out_payload.step_v == STEP_ONE || out_payload.step_v == STEP_THREE))
    else $error("V high gate outside an on step");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_payload))
    else $error("stalled result changed");

endmodule

bind three_phase_pwm_dead_time_top tpwm_checker u_tpwm_checker (
  .clk         (clk),
  .rst         (rst),
  .out_valid   (out_ch.valid),
  .out_ready   (out_ch.ready),
  .out_payload (out_ch.payload)
);
